### src/gdma_pkg.sv
// Package for the gated dual moving average block.
// Holds field widths, register indexes, reset values and window defaults.
// No dependencies; imported by the top level.
package gdma_pkg;

    // Field widths.
    localparam int SAMPLE_W    = 10;
    localparam int GAIN_W      = 6;
    localparam int LEVEL_W     = 16;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    // Full scale of a converter sample, used to invert the inflation reading.
    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 10'd1023;

    // Default window depths.
    localparam int INFLATION_WINDOW_DEF   = 8;
    localparam int VENTILATION_WINDOW_DEF = 8;

    // Register reset values.
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd512;
    localparam logic [GAIN_W-1:0]   GAIN_RST      = 6'd1;
    localparam logic [LEVEL_W-1:0]  CEILING_RST   = 16'd1023;
    localparam logic [LEVEL_W-1:0]  FLOOR_RST     = 16'd0;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VENT_THRESHOLD = 8'd0,
        REG_INFL_GAIN      = 8'd1,
        REG_INFL_CEILING   = 8'd2,
        REG_INFL_FLOOR     = 8'd3
    } t_cfg_reg;

endpackage

### src/gdma_ring.sv
// Ring window with a running sum and a truncated average for the gated moving average.
// The oldest entry is prefetched into a register so the memory read is always registered.
// No package dependencies.
module gdma_ring #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_avg
);

    localparam int CNT_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W   = WIDTH + $clog2(DEPTH);
    localparam int SHIFT   = SUM_W + $clog2(DEPTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Rounded-up reciprocal of the depth; exact floor division for any sum below 2**SUM_W.
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(DEPTH) - 1) / longint'(DEPTH);

    logic [WIDTH-1:0]  r_mem [DEPTH];
    logic [CNT_W-1:0]  r_slot;
    logic              r_full;
    logic [WIDTH-1:0]  r_old;
    logic [SUM_W-1:0]  r_sum;

    logic              last_slot;
    logic [CNT_W-1:0]  n_slot;
    logic              n_full;
    logic [PROD_W-1:0] avg_prod;

    // Next write position and fill state.
    assign last_slot = (r_slot == CNT_W'(DEPTH - 1));
    assign n_slot    = last_slot ? '0 : r_slot + CNT_W'(1);
    assign n_full    = r_full | last_slot;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_slot] <= i_data;
        end
    end

    // Slot, fill flag, running sum and prefetch of the entry that leaves next.
    // Entries never written since reset read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_full <= 1'b0;
            r_old  <= '0;
            r_sum  <= '0;
        end else if (i_push) begin
            r_slot <= n_slot;
            r_full <= n_full;
            r_sum  <= r_sum - SUM_W'(r_old) + SUM_W'(i_data);
            if (!n_full) begin
                r_old <= '0;
            end else if (DEPTH == 1) begin
                r_old <= i_data;
            end else begin
                r_old <= r_mem[n_slot];
            end
        end
    end

    // Average by multiplication with the reciprocal.
    assign avg_prod = PROD_W'(r_sum) * PROD_W'(RECIP_W'(RECIP));
    assign o_avg    = avg_prod[SHIFT +: WIDTH];

endmodule

### src/gated_dual_moving_average_top.sv
// Top level of the gated dual moving average block.
// Depends on gdma_pkg and gdma_ring.
//
// Usage:
//   Input channel (i_s_axis_*): one item per sample tick, tdata holds the
//   ventilation sample in bits [9:0] and the inflation sample in [19:10].
//   Output channel (o_m_axis_*): one item per input item, tdata holds the
//   gated inflation level in bits [15:0].
//   Configuration channel (i_cfg_*): register index and data; always ready.
//   Write registers only while no item is in flight.
// Timing:
//   Four-stage pipeline: one item per cycle is sustained while the output
//   channel is ready. The stages push the ventilation window and multiply
//   by the gain, average and clamp, push the inflation window, then average
//   and gate.
// Reset:
//   Synchronous, active low. Both windows, their sums and slots are cleared,
//   the pipeline empties and registers return to their default values.
// Backpressure:
//   Each stage holds its item while the next is full and stalled, so bubbles
//   fill and the input is taken while a result waits on the output.
module gated_dual_moving_average_top
    import gdma_pkg::*;
#(
    parameter int INFLATION_WINDOW   = INFLATION_WINDOW_DEF,
    parameter int VENTILATION_WINDOW = VENTILATION_WINDOW_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input items
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [9:0] ventilation_sample, [19:10] inflation_sample, [23:20] zero
    input  logic [23:0]            i_s_axis_tdata,
    // Result items
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [15:0] inflation_level
    output logic [15:0]            o_m_axis_tdata,
    // Configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [SAMPLE_W-1:0] r_threshold;
    logic [GAIN_W-1:0]   r_gain;
    logic [LEVEL_W-1:0]  r_ceiling;
    logic [LEVEL_W-1:0]  r_floor;

    // Pipeline registers.
    logic                r1_valid;
    logic [LEVEL_W-1:0]  r1_prod;
    logic                r2_valid;
    logic                r2_blocked;
    logic [LEVEL_W-1:0]  r2_cond;
    logic                r3_valid;
    logic                r3_blocked;
    logic                r4_valid;
    logic [LEVEL_W-1:0]  r4_level;

    logic                rdy1, rdy2, rdy3, rdy4;
    logic                ld1, ld3;
    logic [SAMPLE_W-1:0] vent_sample;
    logic [SAMPLE_W-1:0] infl_sample;
    logic [SAMPLE_W-1:0] infl_inv;
    logic [LEVEL_W-1:0]  n_prod;
    logic [LEVEL_W-1:0]  n_cond;
    logic [SAMPLE_W-1:0] vent_avg;
    logic [LEVEL_W-1:0]  infl_avg;
    logic [LEVEL_W-1:0]  infl_push;
    logic [LEVEL_W-1:0]  n_level;

    assign vent_sample = i_s_axis_tdata[SAMPLE_W-1:0];
    assign infl_sample = i_s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

    // Per-stage ready: a stage takes an item when empty or when its item moves on.
    assign rdy4 = !r4_valid || i_m_axis_tready;
    assign rdy3 = !r3_valid || rdy4;
    assign rdy2 = !r2_valid || rdy3;
    assign rdy1 = !r1_valid || rdy2;
    assign ld1  = i_s_axis_tvalid && rdy1;
    assign ld3  = r2_valid && rdy3;

    assign o_s_axis_tready = rdy1;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r4_valid;
    assign o_m_axis_tdata  = r4_level;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_gain      <= GAIN_RST;
            r_ceiling   <= CEILING_RST;
            r_floor     <= FLOOR_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_VENT_THRESHOLD: r_threshold <= i_cfg_data[SAMPLE_W-1:0];
                REG_INFL_GAIN:      r_gain      <= i_cfg_data[GAIN_W-1:0];
                REG_INFL_CEILING:   r_ceiling   <= i_cfg_data[LEVEL_W-1:0];
                REG_INFL_FLOOR:     r_floor     <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ventilation window, pushed as the item enters the first stage.
    gdma_ring #(
        .DEPTH (VENTILATION_WINDOW),
        .WIDTH (SAMPLE_W)
    ) u_vent_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ld1),
        .i_data  (vent_sample),
        .o_avg   (vent_avg)
    );

    // Stage 1: inverted inflation sample times gain.
    assign infl_inv = SAMPLE_TOP - infl_sample;
    assign n_prod   = LEVEL_W'(infl_inv) * LEVEL_W'(r_gain);

    // Stage 2: clamp to the ceiling, zero at or below the floor.
    always_comb begin
        if (r1_prod > r_ceiling) begin
            n_cond = r_ceiling;
        end else if (r1_prod <= r_floor) begin
            n_cond = '0;
        end else begin
            n_cond = r1_prod;
        end
    end

    // Stage 3 pushes zero into the inflation window while ventilation is blocked.
    assign infl_push = r2_blocked ? '0 : r2_cond;

    gdma_ring #(
        .DEPTH (INFLATION_WINDOW),
        .WIDTH (LEVEL_W)
    ) u_infl_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ld3),
        .i_data  (infl_push),
        .o_avg   (infl_avg)
    );

    // Stage 4: output gate.
    assign n_level = ((infl_avg <= r_floor) || r3_blocked) ? '0 : infl_avg;

    // Valid bits of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (rdy1) begin
                r1_valid <= i_s_axis_tvalid;
            end
            if (rdy2) begin
                r2_valid <= r1_valid;
            end
            if (rdy3) begin
                r3_valid <= r2_valid;
            end
            if (rdy4) begin
                r4_valid <= r3_valid;
            end
        end
    end

    // Payload of the pipeline.
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_prod <= n_prod;
        end
        if (r1_valid && rdy2) begin
            r2_blocked <= (vent_avg > r_threshold);
            r2_cond    <= n_cond;
        end
        if (ld3) begin
            r3_blocked <= r2_blocked;
        end
        if (r3_valid && rdy4) begin
            r4_level <= n_level;
        end
    end

endmodule

### tb/gated_dual_moving_average_top_test.sv
// Self-checking testbench for gated_dual_moving_average_top.
// Depends on gdma_pkg and the block's RTL. A predictor of both windows and the
// gate runs beside the block, and every result item is compared with it.
module gated_dual_moving_average_top_test;
    import gdma_pkg::*;

    localparam int VENT_DEPTH     = VENTILATION_WINDOW_DEF;
    localparam int INFL_DEPTH     = INFLATION_WINDOW_DEF;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 160;
    localparam int SETTLE_CYCLES  = 12;
    localparam int HOLD_CYCLES    = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CFG_INDEX_TOP  = (1 << CFG_INDEX_W) - 1;

    // One input item: ventilation in the low bits, inflation above it.
    typedef struct packed {
        logic [SAMPLE_W-1:0] inflation;
        logic [SAMPLE_W-1:0] ventilation;
    } sample_pair_t;

    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [23:0]            s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [15:0]            m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Predictor state: register copies, both windows, their sums and slots.
    logic [SAMPLE_W-1:0] threshold_cfg = THRESHOLD_RST;
    logic [GAIN_W-1:0]   gain_cfg      = GAIN_RST;
    logic [LEVEL_W-1:0]  ceiling_cfg   = CEILING_RST;
    logic [LEVEL_W-1:0]  floor_cfg     = FLOOR_RST;
    logic [SAMPLE_W-1:0] vent_ring [VENT_DEPTH] = '{default: '0};
    logic [LEVEL_W-1:0]  infl_ring [INFL_DEPTH] = '{default: '0};
    logic [12:0]         vent_total = '0;
    logic [18:0]         infl_total = '0;
    int                  vent_slot  = 0;
    int                  infl_slot  = 0;

    sample_pair_t       pending_samples[$];
    logic [LEVEL_W-1:0] awaited_levels[$];
    sample_pair_t       next_sample;
    logic [LEVEL_W-1:0] wanted_level;
    logic               sample_taken  = 1'b0;
    logic               idle_off      = 1'b0;
    logic               hold_request  = 1'b0;
    int                 send_gap      = 0;
    int                 recv_gap      = 0;
    int                 hold_left     = 0;
    int                 quiet_cycles  = 0;
    int                 error_count   = 0;

    gated_dual_moving_average_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register writes land in the predictor's copies; unknown indexes do nothing.
    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_VENT_THRESHOLD: threshold_cfg = data[SAMPLE_W-1:0];
            REG_INFL_GAIN:      gain_cfg      = data[GAIN_W-1:0];
            REG_INFL_CEILING:   ceiling_cfg   = data[LEVEL_W-1:0];
            REG_INFL_FLOOR:     floor_cfg     = data[LEVEL_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances both windows by one sample tick and returns the gated level.
    function automatic logic [LEVEL_W-1:0] predict_level(input logic [SAMPLE_W-1:0] vent,
                                                         input logic [SAMPLE_W-1:0] infl);
        logic [12:0]        vent_mean;
        logic [18:0]        infl_mean;
        logic [16:0]        scaled;
        logic [LEVEL_W-1:0] stored;
        logic               blocked;

        vent_total = vent_total - 13'(vent_ring[vent_slot]) + 13'(vent);
        vent_ring[vent_slot] = vent;
        vent_slot = (vent_slot + 1) % VENT_DEPTH;
        vent_mean = vent_total / VENT_DEPTH;
        blocked = vent_mean > 13'(threshold_cfg);

        // Invert and scale the inflation reading, then clamp and floor it.
        scaled = 17'(SAMPLE_TOP - infl) * 17'(gain_cfg);
        if (scaled > 17'(ceiling_cfg)) begin
            stored = ceiling_cfg;
        end else if (scaled <= 17'(floor_cfg)) begin
            stored = '0;
        end else begin
            stored = scaled[LEVEL_W-1:0];
        end
        if (blocked) begin
            stored = '0;
        end

        infl_total = infl_total - 19'(infl_ring[infl_slot]) + 19'(stored);
        infl_ring[infl_slot] = stored;
        infl_slot = (infl_slot + 1) % INFL_DEPTH;
        infl_mean = infl_total / INFL_DEPTH;

        if (infl_mean <= 19'(floor_cfg) || blocked) begin
            return '0;
        end
        return infl_mean[LEVEL_W-1:0];
    endfunction

    // Sender: takes items from the pending queue, with random idle bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || sample_taken) begin
            sample_taken = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                next_sample = pending_samples.pop_front();
                s_tdata  <= {4'b0, next_sample};
                s_tvalid <= 1'b1;
                if (!idle_off && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!idle_off && $urandom_range(0, 7) == 0) begin
                    recv_gap = $urandom_range(1, 12);
                end
            end
        end
    end

    // Monitor: predicts on each accepted item, checks each result, runs the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
                quiet_cycles = 0;
            end
            if (s_tvalid && s_tready) begin
                awaited_levels.push_back(predict_level(s_tdata[9:0], s_tdata[19:10]));
                sample_taken = 1'b1;
                quiet_cycles = 0;
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (awaited_levels.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, m_tdata);
                end else begin
                    wanted_level = awaited_levels.pop_front();
                    if (m_tdata !== wanted_level) begin
                        error_count++;
                        $display("%0t: inflation_level mismatch, expected %0d, got %0d",
                                 $time, wanted_level, m_tdata);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, awaited_levels.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Holds valid high across back-to-back writes; the caller lowers it.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    // Waits until every item is sent and every result has come back.
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_samples.size() != 0 || s_tvalid || awaited_levels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pair(input int vent, input int infl);
        sample_pair_t pair;
        pair.ventilation = SAMPLE_W'(vent);
        pair.inflation   = SAMPLE_W'(infl);
        pending_samples.push_back(pair);
    endtask

    // Ventilation mostly hovers around the threshold so the gate keeps
    // switching; inflation is often aimed at the ceiling or floor boundary.
    task automatic queue_random(input int count);
        sample_pair_t pair;
        int           n;
        int           level;
        for (n = 0; n < count; n++) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    pair.ventilation = SAMPLE_W'($urandom);
                end
                2: begin
                    pair.ventilation = $urandom_range(0, 1) ? SAMPLE_TOP : '0;
                end
                default: begin
                    level = int'(threshold_cfg) + int'($urandom_range(0, 80)) - 40;
                    level = (level < 0) ? 0 : (level > 1023) ? 1023 : level;
                    pair.ventilation = SAMPLE_W'(level);
                end
            endcase
            case ($urandom_range(0, 3))
                0: begin
                    pair.inflation = SAMPLE_W'($urandom);
                end
                1: begin
                    pair.inflation = SAMPLE_TOP - SAMPLE_W'($urandom_range(0, 24));
                end
                default: begin
                    if (gain_cfg == '0) begin
                        pair.inflation = SAMPLE_W'($urandom);
                    end else begin
                        level = $urandom_range(0, 1) ? int'(ceiling_cfg) : int'(floor_cfg);
                        level = level / int'(gain_cfg) + int'($urandom_range(0, 2)) - 1;
                        level = (level < 0) ? 0 : (level > 1023) ? 1023 : level;
                        pair.inflation = SAMPLE_TOP - SAMPLE_W'(level);
                    end
                end
            endcase
            pending_samples.push_back(pair);
        end
    endtask

    // Stimulus: directed items at reset settings, then phases of random
    // items under different register settings.
    initial begin
        int phase;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes and alternating bit patterns while the windows ramp up.
        queue_pair(0, 0);
        queue_pair(0, 1023);
        queue_pair(1023, 0);
        queue_pair(10'h2AA, 10'h155);
        queue_pair(10'h155, 10'h2AA);
        // Sustained high ventilation blocks inflation, then low ventilation
        // clears the gate again; both slots wrap on the way.
        repeat (8) queue_pair(1023, 0);
        repeat (9) queue_pair(0, 512);
        wait_drained();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    // Never blocked, largest gain, widest clamp.
                    write_register(REG_VENT_THRESHOLD, 16'hFFFF);
                    write_register(REG_INFL_GAIN, 16'hFFFF);
                    write_register(REG_INFL_CEILING, 16'hFFFF);
                    write_register(REG_INFL_FLOOR, 16'h0000);
                end
                1: begin
                    // Everything at the bottom, floor at the top.
                    write_register(REG_VENT_THRESHOLD, 16'hFC00);
                    write_register(REG_INFL_GAIN, 16'hFFC0);
                    write_register(REG_INFL_CEILING, 16'h0000);
                    write_register(REG_INFL_FLOOR, 16'hFFFF);
                    write_register(CFG_INDEX_W'($urandom_range(REG_INFL_FLOOR + 1,
                                                               CFG_INDEX_TOP)),
                                   CFG_DATA_W'($urandom));
                end
                2: begin
                    // Ceiling below the floor.
                    write_register(REG_VENT_THRESHOLD, 16'd600);
                    write_register(REG_INFL_GAIN, 16'd20);
                    write_register(REG_INFL_CEILING, 16'd3000);
                    write_register(REG_INFL_FLOOR, 16'd3100);
                end
                3: begin
                    // Floor within the sample range.
                    write_register(REG_VENT_THRESHOLD, 16'd400);
                    write_register(REG_INFL_GAIN, 16'd1);
                    write_register(REG_INFL_CEILING, 16'd1023);
                    write_register(REG_INFL_FLOOR, 16'd300);
                end
                default: begin
                    write_register(REG_VENT_THRESHOLD, CFG_DATA_W'($urandom));
                    write_register(REG_INFL_GAIN, CFG_DATA_W'($urandom));
                    write_register(REG_INFL_CEILING, $urandom_range(0, 3) == 0 ?
                                   CFG_DATA_W'($urandom) :
                                   CFG_DATA_W'($urandom_range(500, 20000)));
                    write_register(REG_INFL_FLOOR, CFG_DATA_W'($urandom_range(0, 2000)));
                end
            endcase
            @(negedge i_clk);
            cfg_valid <= 1'b0;

            if (phase == PHASES - 1) begin
                idle_off = 1'b1;
            end
            queue_random(PHASE_ITEMS / 2);
            if (phase == 4) begin
                // Long receiver hold-off while the sender keeps offering items.
                hold_request = 1'b1;
            end
            if (phase == 5) begin
                // Sender pauses until every result is back.
                wait_drained();
            end
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
